@@ src/ims_pkg.sv @@
// Shared definitions for the interval merge block: default sizes and the
// command and status groups passed between controller and datapath.
// No dependencies.
package ims_pkg;

  localparam int unsigned MaxIntervalsDef = 32;
  localparam int unsigned ValueBitsDef    = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // latch the incoming item, start insertion at the top
    logic set_drop;    // store full: note the dropped item
    logic ins_rd;      // read the entry below the insertion slot
    logic ins_shift;   // move that entry up one slot
    logic ins_place;   // write the new pair into the slot, bump the count
    logic mrg_init;    // start the merge pass at entry zero
    logic mrg_rd;      // read the next sorted entry
    logic mrg_step;    // fold that entry into the running merged interval
    logic mrg_flush;   // write the final merged interval back
    logic emit_init;   // start emitting from the highest merged entry
    logic emit_rd;     // read the next merged entry
    logic emit_load;   // move it into the output register
    logic clear_set;   // set done: empty the store
  } ims_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic less;        // new pair sorts below the entry just read
    logic pos_zero;    // insertion slot reached the bottom
    logic full;        // store holds the maximum number of intervals
    logic in_last;     // last flag on the input port
    logic last_q;      // last flag of the item being inserted
    logic mrg_end;     // entry being folded is the last stored one
    logic emit_last;   // entry being emitted is the lowest merged one
    logic out_free;    // output register can take an item this cycle
  } ims_sts_t;

endpackage

@@ src/ims_ctrl.sv @@
// Sequencer for the interval merge block: insertion, merge pass and emit.
// Depends on ims_pkg for the command and status types.
module ims_ctrl import ims_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ims_sts_t sts_i,
  output ims_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    StIdle     = 8'b0000_0001,
    StInsRd    = 8'b0000_0010,
    StInsCmp   = 8'b0000_0100,
    StMrgRd    = 8'b0000_1000,
    StMrgStep  = 8'b0001_0000,
    StMrgFlush = 8'b0010_0000,
    StEmitRd   = 8'b0100_0000,
    StEmitLd   = 8'b1000_0000
  } ims_state_e;

  ims_state_e state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (sts_i.full) begin
            cmd_o.set_drop = 1'b1;
            if (sts_i.in_last) begin
              cmd_o.mrg_init = 1'b1;
              state_d        = StMrgRd;
            end
          end else begin
            state_d = StInsRd;
          end
        end
      end
      StInsRd: begin
        if (sts_i.pos_zero) begin
          cmd_o.ins_place = 1'b1;
          if (sts_i.last_q) begin
            cmd_o.mrg_init = 1'b1;
            state_d        = StMrgRd;
          end else begin
            state_d = StIdle;
          end
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = StInsCmp;
        end
      end
      StInsCmp: begin
        if (sts_i.less) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = StInsRd;
        end else begin
          cmd_o.ins_place = 1'b1;
          if (sts_i.last_q) begin
            cmd_o.mrg_init = 1'b1;
            state_d        = StMrgRd;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StMrgRd: begin
        cmd_o.mrg_rd = 1'b1;
        state_d      = StMrgStep;
      end
      StMrgStep: begin
        cmd_o.mrg_step = 1'b1;
        state_d        = sts_i.mrg_end ? StMrgFlush : StMrgRd;
      end
      StMrgFlush: begin
        cmd_o.mrg_flush = 1'b1;
        cmd_o.emit_init = 1'b1;
        state_d         = StEmitRd;
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = StEmitLd;
      end
      StEmitLd: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = StIdle;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/ims_dpath.sv @@
// Datapath for the interval merge block: interval store, counters,
// running merged interval and output register.
// Depends on ims_pkg for the command and status types.
module ims_dpath import ims_pkg::*; #(
  parameter int unsigned MaxIntervals = MaxIntervalsDef,
  parameter int unsigned ValueBits    = ValueBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [ValueBits-1:0] start_value_i,
  input  logic signed [ValueBits-1:0] end_value_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ValueBits-1:0] merged_start_o,
  output logic signed [ValueBits-1:0] merged_end_o,
  output logic                        last_out_o,
  output logic                        overflow_o,
  input  ims_cmd_t                    cmd_i,
  output ims_sts_t                    sts_o
);

  localparam int unsigned IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int unsigned CntW = $clog2(MaxIntervals + 1);
  localparam int unsigned PairW = 2 * ValueBits;

  logic [PairW-1:0] mem [MaxIntervals];
  logic [PairW-1:0] rd_q;

  logic signed [ValueBits-1:0] new_lo_q, new_hi_q;
  logic                        last_q;
  logic [CntW-1:0]             cnt_q, pos_q, idx_q, nm_q;
  logic                        drop_q;
  logic signed [ValueBits-1:0] cur_lo_q, cur_hi_q;

  logic                        out_valid_q, out_last_q, out_ovf_q;
  logic signed [ValueBits-1:0] out_lo_q, out_hi_q;

  logic signed [ValueBits-1:0] rd_lo, rd_hi;
  logic                        overlap, first;
  logic                        we, re;
  logic [IdxW-1:0]             waddr, raddr;
  logic [PairW-1:0]            wdata;
  logic [CntW-1:0]             pos_m1, idx_m1, nm_m1;
  logic                        out_free;

  assign rd_lo   = $signed(rd_q[PairW-1:ValueBits]);
  assign rd_hi   = $signed(rd_q[ValueBits-1:0]);
  assign first   = (nm_q == '0);
  assign overlap = (rd_lo <= cur_hi_q);
  assign pos_m1  = pos_q - CntW'(1);
  assign idx_m1  = idx_q - CntW'(1);
  assign nm_m1   = nm_q - CntW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // single write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd_i.ins_shift) begin
      we    = 1'b1;
      waddr = pos_q[IdxW-1:0];
      wdata = rd_q;
    end else if (cmd_i.ins_place) begin
      we    = 1'b1;
      waddr = pos_q[IdxW-1:0];
      wdata = {new_lo_q, new_hi_q};
    end else if ((cmd_i.mrg_step && !first && !overlap) || cmd_i.mrg_flush) begin
      // merged entries go back below the read index, so nothing unread is lost
      we    = 1'b1;
      waddr = nm_m1[IdxW-1:0];
      wdata = {cur_lo_q, cur_hi_q};
    end else begin
      we = 1'b0;
    end
  end

  // single read port
  always_comb begin
    re    = 1'b1;
    raddr = '0;
    priority if (cmd_i.ins_rd) begin
      raddr = pos_m1[IdxW-1:0];
    end else if (cmd_i.mrg_rd) begin
      raddr = idx_q[IdxW-1:0];
    end else if (cmd_i.emit_rd) begin
      raddr = idx_m1[IdxW-1:0];
    end else begin
      re = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      new_lo_q <= start_value_i;
      new_hi_q <= end_value_i;
      last_q   <= last_in_i;
    end
    if (cmd_i.mrg_step) begin
      if (first || !overlap) begin
        cur_lo_q <= rd_lo;
        cur_hi_q <= rd_hi;
      end else if (rd_hi > cur_hi_q) begin
        cur_hi_q <= rd_hi;
      end
    end
    if (cmd_i.emit_load) begin
      out_lo_q   <= rd_lo;
      out_hi_q   <= rd_hi;
      out_last_q <= (idx_q == CntW'(1));
      out_ovf_q  <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
      nm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        pos_q <= cnt_q;
      end else if (cmd_i.ins_shift) begin
        pos_q <= pos_m1;
      end
      if (cmd_i.set_drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.clear_set) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end else if (cmd_i.ins_place) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.mrg_init) begin
        idx_q <= '0;
        nm_q  <= '0;
      end else if (cmd_i.mrg_step) begin
        idx_q <= idx_q + CntW'(1);
        if (first || !overlap) begin
          nm_q <= nm_q + CntW'(1);
        end
      end else if (cmd_i.emit_init) begin
        idx_q <= nm_q;
      end else if (cmd_i.emit_load) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.less      = (new_lo_q < rd_lo) || ((new_lo_q == rd_lo) && (new_hi_q < rd_hi));
    sts_o.pos_zero  = (pos_q == '0);
    sts_o.full      = (cnt_q == CntW'(MaxIntervals));
    sts_o.in_last   = last_in_i;
    sts_o.last_q    = last_q;
    sts_o.mrg_end   = ((idx_q + CntW'(1)) == cnt_q);
    sts_o.emit_last = (idx_q == CntW'(1));
    sts_o.out_free  = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign merged_start_o = out_lo_q;
  assign merged_end_o   = out_hi_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

@@ src/interval_merge_sorted.sv @@
// Interval merge block collects a set of closed intervals, one start/end pair
// per item, keeping them sorted by start then end with an insertion sort in a
// single-port-write, single-port-read store. An item goes in below the top past
// every larger entry, each of which is shifted up one slot; each step of the
// shift costs one read and one write of the store. The item flagged last
// closes the set; the merge pass then reads each stored interval once, and
// each merged interval is read back and emitted, highest start first, the
// final one marked. Intervals arriving while the store is full are dropped
// and every result of that set carries the overflow flag. Input is stalled
// from the accept of an item until its insertion is finished, and for the
// last item of a set until the merge and emit are finished too.
// Depends on ims_pkg, ims_ctrl and ims_dpath.
module interval_merge_sorted import ims_pkg::*; #(
  parameter int unsigned MaxIntervals = MaxIntervalsDef,
  parameter int unsigned ValueBits    = ValueBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ValueBits-1:0] start_value_i,
  input  logic signed [ValueBits-1:0] end_value_i,
  input  logic                        last_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ValueBits-1:0] merged_start_o,
  output logic signed [ValueBits-1:0] merged_end_o,
  output logic                        last_out_o,
  output logic                        overflow_o
);

  ims_cmd_t cmd;
  ims_sts_t sts;

  ims_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ims_dpath #(
    .MaxIntervals (MaxIntervals),
    .ValueBits    (ValueBits)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_value_i  (start_value_i),
    .end_value_i    (end_value_i),
    .last_in_i      (last_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_start_o (merged_start_o),
    .merged_end_o   (merged_end_o),
    .last_out_o     (last_out_o),
    .overflow_o     (overflow_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

@@ tb/sv/interval_merge_sorted_test.sv @@
`timescale 1ns / 100ps
// Testbench for interval_merge_sorted: sends sets of intervals under random input gaps
// and output stalls, predicts the merged intervals and checks every output item.
// Depends on ims_pkg and the interval_merge_sorted RTL.
module interval_merge_sorted_test import ims_pkg::*; ();

  localparam int unsigned NumSlots = MaxIntervalsDef;
  localparam int unsigned VBits    = ValueBitsDef;

  typedef logic signed [VBits-1:0] value_t;

  localparam value_t VMin = {1'b1, {(VBits-1){1'b0}}};
  localparam value_t VMax = {1'b0, {(VBits-1){1'b1}}};

  typedef struct packed {
    value_t lo;
    value_t hi;
    logic   last;
    logic   ovf;
  } merged_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  logic   in_stall_o;
  value_t start_value_i = '0;
  value_t end_value_i   = '0;
  logic   last_in_i     = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i   = 1'b0;
  value_t merged_start_o;
  value_t merged_end_o;
  logic   last_out_o;
  logic   overflow_o;

  // Predicted block state
  value_t      sorted_lo[NumSlots];
  value_t      sorted_hi[NumSlots];
  int unsigned held_count  = 0;
  logic        set_dropped = 1'b0;
  merged_t     merged_due[$];

  int unsigned errors     = 0;
  bit          quiet      = 1'b0;
  int unsigned stall_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  interval_merge_sorted #(
    .MaxIntervals(NumSlots),
    .ValueBits   (VBits)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_value_i (start_value_i),
    .end_value_i   (end_value_i),
    .last_in_i     (last_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .merged_start_o(merged_start_o),
    .merged_end_o  (merged_end_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic value_t random_value(bit wide);
    if (wide) return value_t'($urandom_range(0, (1 << VBits) - 1));
    return value_t'(int'($urandom_range(0, 40)) - 20);
  endfunction

  // Insert one interval into the sorted store; on the last item merge the set
  // and queue the merged intervals, highest start first.
  function automatic void fold_interval(value_t s, value_t e, logic last);
    value_t      run_lo[NumSlots];
    value_t      run_hi[NumSlots];
    int unsigned pos;
    int unsigned nm;
    merged_t     m;
    if (held_count < NumSlots) begin
      pos = held_count;
      // equal pairs stay ahead of the new one
      while (pos > 0 && (s < sorted_lo[pos-1] ||
                         (s == sorted_lo[pos-1] && e < sorted_hi[pos-1]))) begin
        sorted_lo[pos] = sorted_lo[pos-1];
        sorted_hi[pos] = sorted_hi[pos-1];
        pos--;
      end
      sorted_lo[pos] = s;
      sorted_hi[pos] = e;
      held_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    nm = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (nm > 0 && sorted_lo[i] <= run_hi[nm-1]) begin
        if (sorted_hi[i] > run_hi[nm-1]) run_hi[nm-1] = sorted_hi[i];
      end else begin
        run_lo[nm] = sorted_lo[i];
        run_hi[nm] = sorted_hi[i];
        nm++;
      end
    end
    for (int k = int'(nm) - 1; k >= 0; k--) begin
      m.lo   = run_lo[k];
      m.hi   = run_hi[k];
      m.last = (k == 0);
      m.ovf  = set_dropped;
      merged_due = {merged_due, m};
    end
    held_count  = 0;
    set_dropped = 1'b0;
  endfunction

  task automatic send_interval(input value_t s, input value_t e, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_value_i <= s;
    end_value_i   <= e;
    last_in_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_interval(s, e, last);
  endtask

  // Drop valid and wait until the whole set has come out
  task automatic finish_set();
    in_valid_i <= 1'b0;
    while (merged_due.size() > 0) @(posedge clk_i);
  endtask

  task automatic send_random_set(input int unsigned n, input bit wide);
    value_t s;
    value_t e;
    value_t t;
    for (int unsigned i = 0; i < n; i++) begin
      s = random_value(wide);
      if ($urandom_range(0, 99) < 85) begin
        if (wide) begin
          e = random_value(1'b1);
          if (e < s) begin
            t = s;
            s = e;
            e = t;
          end
        end else begin
          e = s + value_t'($urandom_range(0, 6));
        end
      end else begin
        e = random_value(wide);
      end
      send_interval(s, e, i == n - 1);
    end
    finish_set();
  endtask

  task automatic report_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    errors++;
  endtask

  // Output checker
  always @(posedge clk_i) begin
    merged_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (merged_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual start %0d end %0d",
                 $time, merged_start_o, merged_end_o);
        errors++;
      end else begin
        want = merged_due.pop_front();
        if (merged_start_o !== want.lo)
          report_field("merged_start", 32'(want.lo), 32'(merged_start_o));
        if (merged_end_o !== want.hi)
          report_field("merged_end", 32'(want.hi), 32'(merged_end_o));
        if (last_out_o !== want.last)
          report_field("last_out", 32'(want.last), 32'(last_out_o));
        if (overflow_o !== want.ovf)
          report_field("overflow", 32'(want.ovf), 32'(overflow_o));
      end
    end
  end

  // Output stall pattern
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic test_single();
    send_interval(VMin, VMax, 1'b1);
    finish_set();
  endtask

  // Touching intervals merge, a disjoint one stays apart
  task automatic test_touching();
    send_interval(value_t'(1), value_t'(3), 1'b0);
    send_interval(value_t'(10), value_t'(12), 1'b0);
    send_interval(value_t'(3), value_t'(5), 1'b1);
    finish_set();
  endtask

  // Out of order arrival with nested intervals
  task automatic test_unsorted();
    send_interval(value_t'(20), value_t'(30), 1'b0);
    send_interval(value_t'(5), value_t'(8), 1'b0);
    send_interval(value_t'(22), value_t'(25), 1'b0);
    send_interval(value_t'(-4), value_t'(0), 1'b0);
    send_interval(value_t'(9), value_t'(9), 1'b1);
    finish_set();
  endtask

  task automatic test_reversed_ends();
    send_interval(value_t'(10), value_t'(2), 1'b0);
    send_interval(value_t'(3), value_t'(4), 1'b0);
    send_interval(value_t'(5), value_t'(12), 1'b1);
    finish_set();
  endtask

  task automatic test_equal_pairs();
    send_interval(value_t'(7), value_t'(9), 1'b0);
    send_interval(value_t'(7), value_t'(9), 1'b0);
    send_interval(value_t'(7), value_t'(9), 1'b0);
    send_interval(value_t'(7), value_t'(8), 1'b1);
    finish_set();
  endtask

  task automatic test_extremes();
    send_interval(VMax, VMax, 1'b0);
    send_interval(VMin, VMin, 1'b1);
    finish_set();
    send_interval(VMin, VMax, 1'b0);
    send_interval(value_t'(0), value_t'(-1), 1'b1);
    finish_set();
  endtask

  // Exactly full, then a set whose tail, last item included, is dropped
  task automatic test_capacity();
    send_random_set(NumSlots, 1'b0);
    send_random_set(NumSlots + 2, 1'b1);
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < 24) begin
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      quiet = ($urandom_range(0, 4) == 0);
      send_random_set(n, $urandom_range(0, 99) < 25);
      quiet = 1'b0;
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single();
    test_touching();
    test_unsorted();
    test_reversed_ends();
    test_equal_pairs();
    test_extremes();
    test_capacity();
    test_random_sets();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("interval_merge_sorted_test: PASS");
    end else begin
      $display("interval_merge_sorted_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("interval_merge_sorted_test: FAIL");
    $finish;
  end

endmodule
